### hw/rtl/vlc_pkg.sv
// Shared types and constants for the Vigenere letter cipher.
// No dependencies; every other file except vlc_ram refers to it by scoped name.
package vlc_pkg;

    localparam int KEY_DEPTH_DEF = 16;
    localparam int LETTER_W      = 7;
    localparam int SHIFT_W       = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [LETTER_W-1:0] LETTER_A = 7'd65;
    localparam logic [LETTER_W-1:0] LETTER_Z = 7'd90;
    localparam logic [LETTER_W-1:0] KEY_BASE = 7'd64;
    localparam logic [LETTER_W:0]   ALPHA_N  = 8'd26;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [LETTER_W-1:0] letter;
        logic                start_req;
    } req_word_t;

    typedef struct packed {
        logic [LETTER_W-1:0] out_letter;
        logic                no_key;
    } rsp_word_t;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_NOKEY,
        OP_SHIFT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [LETTER_W-1:0] letter;
        logic [SHIFT_W-1:0]  shift;
    } job_t;

    function automatic logic is_upper(input logic [LETTER_W-1:0] c);
        return (c >= LETTER_A) && (c <= LETTER_Z);
    endfunction

endpackage

### hw/rtl/vigenere_letter_cipher.sv
// Top level of the Vigenere letter cipher: front end, job queue, back end, mode register.
// Depends on vlc_pkg, vlc_front, vlc_queue and vlc_back.
//
// One word is accepted every clock, key or text, and one result word per text word
// can leave every clock; key words produce no result. A text word's result reaches rsp
// through the front-end stage, which takes the key store read at the edge that accepts
// it, then one pass through the two-entry queue, and then the result register.
// A stalled result side backs up through the queue to req_ready. The key store holds
// KEY_DEPTH shifts in a RAM; a key word with start_req clears it, and a text word with
// start_req restarts the key at its first letter. Write cfg_wdata (1 = decrypt) only
// while no word is in flight.
module vigenere_letter_cipher #(
    parameter int KEY_DEPTH = vlc_pkg::KEY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  vlc_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output vlc_pkg::rsp_word_t rsp,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);

    logic          decrypt_mode_reg;
    logic          push_valid;
    logic          push_ready;
    vlc_pkg::job_t push_job;
    logic          pop_valid;
    logic          pop_ready;
    vlc_pkg::job_t pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            decrypt_mode_reg <= cfg_wdata;
        end
    end

    vlc_front #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    vlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    vlc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .decrypt_mode (decrypt_mode_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp)
    );

    a_key_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.kind == vlc_pkg::KIND_KEY)) |=> !push_valid
            || $past(push_valid && !push_ready))
        else $error("key word produced a job");

    a_text_job: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.kind == vlc_pkg::KIND_TEXT)) |=> push_valid)
        else $error("text word lost in front end");

    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (decrypt_mode_reg == $past(cfg_wdata)))
        else $error("mode register missed a write");

endmodule

### hw/rtl/vlc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/vlc_front.sv
// Front end: accepts words, keeps key length and position, owns the key store,
// and hands classified jobs to the queue. Depends on vlc_pkg and vlc_ram.
module vlc_front #(
    parameter int KEY_DEPTH = vlc_pkg::KEY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  vlc_pkg::req_word_t req,
    output logic               push_valid,
    input  logic               push_ready,
    output vlc_pkg::job_t      push_job
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LW = $clog2(KEY_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(KEY_DEPTH);

    logic [LW-1:0] key_length_reg, key_length_next;
    logic [AW-1:0] key_pos_reg, key_pos_next;
    logic          stage_valid_reg, stage_valid_next;
    vlc_pkg::op_t  stage_op_reg, stage_op_next;
    logic [vlc_pkg::LETTER_W-1:0] stage_letter_reg;

    logic          accept;
    logic          upper;
    logic [LW-1:0] len_base;
    logic [AW-1:0] pos_base;
    logic [AW-1:0] pos_eff;
    logic [LW-1:0] pos_inc;
    logic          ram_we;
    logic          ram_re;
    logic [vlc_pkg::SHIFT_W-1:0] ram_wdata;
    logic [vlc_pkg::SHIFT_W-1:0] ram_rdata;

    assign req_ready = !stage_valid_reg || push_ready;
    assign accept    = req_valid && req_ready;
    assign upper     = vlc_pkg::is_upper(req.letter);
    assign ram_wdata = vlc_pkg::SHIFT_W'(req.letter - vlc_pkg::KEY_BASE);

    always_comb
    begin
        key_length_next = key_length_reg;
        key_pos_next    = key_pos_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        stage_op_next   = stage_op_reg;
        len_base        = req.start_req ? '0 : key_length_reg;
        pos_base        = req.start_req ? '0 : key_pos_reg;
        pos_eff         = (LW'(pos_base) >= key_length_reg) ? '0 : pos_base;
        pos_inc         = LW'(pos_eff) + LW'(1);
        stage_valid_next = stage_valid_reg && !push_ready;

        if (accept)
        begin
            unique case (req.kind)
                vlc_pkg::KIND_KEY:
                begin
                    key_length_next = len_base;
                    if (req.start_req)
                    begin
                        key_pos_next = '0;
                    end
                    if (upper && (len_base < DEPTH_L))
                    begin
                        ram_we          = 1'b1;
                        key_length_next = len_base + LW'(1);
                    end
                end
                vlc_pkg::KIND_TEXT:
                begin
                    stage_valid_next = 1'b1;
                    key_pos_next     = pos_base;
                    if (key_length_reg == '0)
                    begin
                        stage_op_next = vlc_pkg::OP_NOKEY;
                    end
                    else if (upper)
                    begin
                        stage_op_next = vlc_pkg::OP_SHIFT;
                        ram_re        = 1'b1;
                        key_pos_next  = (pos_inc >= key_length_reg) ? '0 : pos_inc[AW-1:0];
                    end
                    else
                    begin
                        stage_op_next = vlc_pkg::OP_PASS;
                    end
                end
                default:
                begin
                    stage_valid_next = stage_valid_reg && !push_ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg  <= '0;
            key_pos_reg     <= '0;
            stage_valid_reg <= 1'b0;
            stage_op_reg    <= vlc_pkg::OP_PASS;
        end
        else
        begin
            key_length_reg  <= key_length_next;
            key_pos_reg     <= key_pos_next;
            stage_valid_reg <= stage_valid_next;
            stage_op_reg    <= stage_op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req.kind == vlc_pkg::KIND_TEXT))
        begin
            stage_letter_reg <= req.letter;
        end
    end

    vlc_ram #(
        .WIDTH (vlc_pkg::SHIFT_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_base[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pos_eff),
        .rdata (ram_rdata)
    );

    assign push_valid       = stage_valid_reg;
    assign push_job.op      = stage_op_reg;
    assign push_job.letter  = stage_letter_reg;
    assign push_job.shift   = ram_rdata;

    a_pos_in_key: assert property (@(posedge clk) disable iff (!rst_n)
        (key_length_reg != '0) |-> (LW'(key_pos_reg) < key_length_reg))
        else $error("key position beyond key length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_length_reg <= DEPTH_L)
        else $error("key length beyond store depth");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !push_ready) |=>
            (stage_valid_reg && $stable(stage_op_reg) && $stable(stage_letter_reg)))
        else $error("stalled stage word lost");

endmodule

### hw/rtl/vlc_queue.sv
// Two-entry job queue between front end and back end.
// Depends on vlc_pkg.
module vlc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  vlc_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output vlc_pkg::job_t pop_job
);

    localparam int PW = $clog2(vlc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(vlc_pkg::QUEUE_DEPTH + 1);

    vlc_pkg::job_t  slot_reg [vlc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(vlc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + PW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(vlc_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count missed a push");

endmodule

### hw/rtl/vlc_back.sv
// Back end: applies the key shift with wrap inside A..Z and holds the result word.
// Depends on vlc_pkg.
module vlc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               decrypt_mode,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  vlc_pkg::job_t      pop_job,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output vlc_pkg::rsp_word_t rsp
);

    localparam int W = vlc_pkg::LETTER_W + 1;

    logic               rsp_valid_reg, rsp_valid_next;
    vlc_pkg::rsp_word_t rsp_reg, rsp_next;
    logic [W-1:0]       sum;
    logic [W-1:0]       diff;
    logic [W-1:0]       result;
    logic               take;

    assign pop_ready = !rsp_valid_reg || rsp_ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        sum  = W'(pop_job.letter) + W'(pop_job.shift);
        diff = W'(pop_job.letter) - W'(pop_job.shift);
        if (decrypt_mode)
        begin
            result = (diff < W'(vlc_pkg::LETTER_A)) ? diff + vlc_pkg::ALPHA_N : diff;
        end
        else
        begin
            result = (sum > W'(vlc_pkg::LETTER_Z)) ? sum - vlc_pkg::ALPHA_N : sum;
        end

        rsp_next.out_letter = pop_job.letter;
        rsp_next.no_key     = 1'b0;
        unique case (pop_job.op)
            vlc_pkg::OP_PASS:  rsp_next.no_key = 1'b0;
            vlc_pkg::OP_NOKEY: rsp_next.no_key = 1'b1;
            vlc_pkg::OP_SHIFT: rsp_next.out_letter = result[vlc_pkg::LETTER_W-1:0];
            default:           rsp_next.no_key = 1'b0;
        endcase

        rsp_valid_next = take || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (pop_job.op == vlc_pkg::OP_SHIFT)) |=>
            vlc_pkg::is_upper(rsp_reg.out_letter))
        else $error("shifted letter outside A..Z");

    a_nokey_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (pop_job.op == vlc_pkg::OP_NOKEY)) |=>
            (rsp_reg.no_key && (rsp_reg.out_letter == $past(pop_job.letter))))
        else $error("empty-key word altered");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |-> !take)
        else $error("result register overwritten while waiting");

endmodule

### tb/sv/vlc_cipher_checker.sv
// Checker for the Vigenere letter cipher: watches the request, result and mode ports,
// predicts each result word from its own key store and compares it. Depends on vlc_pkg.
module vlc_cipher_checker #(
    parameter int KEY_DEPTH = vlc_pkg::KEY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  vlc_pkg::req_word_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  vlc_pkg::rsp_word_t rsp,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output int                 fail_count,
    output int                 letters_due,
    output int                 letters_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [vlc_pkg::SHIFT_W-1:0] key_shift [KEY_DEPTH];
    int                          key_len;
    int                          key_pos;
    logic                        decrypt;
    vlc_pkg::rsp_word_t          cipher_due [$];
    int                          fails;
    int                          checked;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    // advance the key store by one accepted word, queue the cipher letter for text
    task automatic absorb_word(input vlc_pkg::req_word_t w);
        vlc_pkg::rsp_word_t want;
        logic [7:0]         sum;
        logic               upper;
        upper = (w.letter >= vlc_pkg::LETTER_A) && (w.letter <= vlc_pkg::LETTER_Z);
        if (w.kind == vlc_pkg::KIND_KEY)
        begin
            if (w.start_req)
            begin
                key_len = 0;
                key_pos = 0;
            end
            if (upper && key_len < KEY_DEPTH)
            begin
                key_shift[key_len] = vlc_pkg::SHIFT_W'(w.letter - vlc_pkg::KEY_BASE);
                key_len++;
            end
        end
        else
        begin
            if (w.start_req)
                key_pos = 0;
            want.out_letter = w.letter;
            want.no_key     = 1'b0;
            if (key_len == 0)
                want.no_key = 1'b1;
            else if (upper)
            begin
                if (key_pos >= key_len)
                    key_pos = 0;
                if (decrypt)
                begin
                    sum = {1'b0, w.letter} - 8'(key_shift[key_pos]);
                    if (sum < 8'(vlc_pkg::LETTER_A))
                        sum = sum + vlc_pkg::ALPHA_N;
                end
                else
                begin
                    sum = {1'b0, w.letter} + 8'(key_shift[key_pos]);
                    if (sum > 8'(vlc_pkg::LETTER_Z))
                        sum = sum - vlc_pkg::ALPHA_N;
                end
                want.out_letter = sum[vlc_pkg::LETTER_W-1:0];
                key_pos++;
                if (key_pos >= key_len)
                    key_pos = 0;
            end
            cipher_due = {cipher_due, want};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vlc_pkg::rsp_word_t want;
        if (!rst_n)
        begin
            cipher_due.delete();
            key_len = 0;
            key_pos = 0;
            decrypt = 1'b0;
            fails   = 0;
            checked = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (cipher_due.size() == 0)
                    report_mismatch("result word with none expected", rsp.out_letter, 0);
                else
                begin
                    want = cipher_due.pop_front();
                    checked++;
                    if (rsp.out_letter !== want.out_letter)
                        report_mismatch("out_letter", rsp.out_letter, want.out_letter);
                    if (rsp.no_key !== want.no_key)
                        report_mismatch("no_key", rsp.no_key, want.no_key);
                end
            end
            if (req_valid && req_ready)
                absorb_word(req);
            if (cfg_we)
                decrypt = cfg_wdata;
        end
        fail_count      <= fails;
        letters_due     <= cipher_due.size();
        letters_checked <= checked;
    end

endmodule

### tb/sv/tb.sv
// Testbench top for vigenere_letter_cipher: clock, reset, word stimulus with idle and
// stall phases, mode writes between phases and the verdict. Depends on vlc_pkg and
// vlc_cipher_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 310;
    localparam int SETTLE       = 6;
    localparam int HOLD_CYCLES  = 400;

    localparam int   SEND_TAB  [6] = '{0, 58, 0, 11, 0, 0};
    localparam int   STALL_TAB [6] = '{0, 0, 58, 11, 0, 0};
    localparam logic MODE_TAB  [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    vlc_pkg::req_word_t req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    vlc_pkg::rsp_word_t rsp;
    logic               cfg_we    = 1'b0;
    logic               cfg_wdata = 1'b0;

    int   fail_count;
    int   letters_due;
    int   letters_checked;
    int   cycle_count = 0;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_left   = 0;
    int   words_sent  = 0;
    int   letters_sent = 0;

    vigenere_letter_cipher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    vlc_cipher_checker cipher_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .letters_due     (letters_due),
        .letters_checked (letters_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_word(input logic kind, input logic [vlc_pkg::LETTER_W-1:0] letter,
                             input logic start);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        req.kind      <= kind;
        req.letter    <= letter;
        req.start_req <= start;
        do
            @(posedge clk);
        while (!req_ready);
        words_sent++;
    endtask

    task automatic set_mode(input logic decrypt);
        @(posedge clk);
        while (letters_due != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= decrypt;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [vlc_pkg::LETTER_W-1:0] any_letter();
        return vlc_pkg::LETTER_W'(vlc_pkg::LETTER_A + $urandom_range(25));
    endfunction

    task automatic send_key_run();
        int                           n;
        int                           k;
        logic                         fresh;
        logic [vlc_pkg::LETTER_W-1:0] l;
        n     = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
        fresh = ($urandom_range(9) != 0);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(19) == 0)
                l = vlc_pkg::LETTER_W'($urandom_range(127));
            else
                l = any_letter();
            send_word(vlc_pkg::KIND_KEY, l, fresh && k == 0);
            if (l >= vlc_pkg::LETTER_A && l <= vlc_pkg::LETTER_Z && k < vlc_pkg::KEY_DEPTH_DEF)
                letters_sent++;
        end
    endtask

    task automatic send_text_word();
        int                           n;
        int                           k;
        logic                         start;
        logic [vlc_pkg::LETTER_W-1:0] l;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
        begin
            if (k == 0)
                start = ($urandom_range(9) != 0);
            else
                start = ($urandom_range(19) == 0);
            if ($urandom_range(14) == 0)
                l = vlc_pkg::LETTER_W'($urandom_range(127));
            else
                l = any_letter();
            send_word(vlc_pkg::KIND_TEXT, l, start);
            letters_sent++;
        end
    endtask

    initial
    begin
        int ph;
        int goal;
        int r;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty key, shifts of A and Z, wrap past Z, non-letters, clear by a non-letter
        send_word(vlc_pkg::KIND_TEXT, vlc_pkg::LETTER_A, 1'b0);
        send_word(vlc_pkg::KIND_TEXT, 7'h00, 1'b1);
        send_word(vlc_pkg::KIND_KEY, vlc_pkg::LETTER_Z, 1'b1);
        send_word(vlc_pkg::KIND_KEY, 7'h7F, 1'b0);
        send_word(vlc_pkg::KIND_KEY, vlc_pkg::LETTER_A, 1'b0);
        send_word(vlc_pkg::KIND_TEXT, vlc_pkg::LETTER_A, 1'b1);
        send_word(vlc_pkg::KIND_TEXT, vlc_pkg::LETTER_Z, 1'b0);
        send_word(vlc_pkg::KIND_TEXT, 7'h00, 1'b0);
        send_word(vlc_pkg::KIND_TEXT, vlc_pkg::LETTER_Z, 1'b0);
        send_word(vlc_pkg::KIND_TEXT, 7'h7F, 1'b1);
        send_word(vlc_pkg::KIND_KEY, vlc_pkg::KEY_BASE, 1'b1);
        send_word(vlc_pkg::KIND_TEXT, vlc_pkg::LETTER_A + 7'd12, 1'b1);
        req_valid <= 1'b0;

        // decrypt: wrap below A
        set_mode(1'b1);
        send_word(vlc_pkg::KIND_KEY, vlc_pkg::LETTER_Z, 1'b1);
        send_word(vlc_pkg::KIND_KEY, vlc_pkg::LETTER_A, 1'b0);
        send_word(vlc_pkg::KIND_TEXT, vlc_pkg::LETTER_A, 1'b1);
        send_word(vlc_pkg::KIND_TEXT, vlc_pkg::LETTER_Z, 1'b0);
        send_word(vlc_pkg::KIND_TEXT, vlc_pkg::LETTER_A, 1'b0);
        send_word(vlc_pkg::KIND_TEXT, 7'h7F, 1'b0);
        req_valid <= 1'b0;

        goal = 0;
        for (ph = 0; ph < 6; ph++)
        begin
            set_mode(MODE_TAB[ph]);
            idle_pct   = SEND_TAB[ph];
            stall_pct <= STALL_TAB[ph];
            if (ph == 4)
                hold_req <= 1'b1;
            goal += PHASE_WORDS;
            while (letters_sent < goal)
            begin
                r = $urandom_range(99);
                if (r < 3)
                    send_word(vlc_pkg::KIND_KEY, vlc_pkg::LETTER_W'($urandom_range(64)), 1'b1);
                else if (r < 22)
                    send_key_run();
                else
                    send_text_word();
            end
            req_valid <= 1'b0;
        end

        @(posedge clk);
        while (letters_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d words over six idle/stall phases in both modes; %0d cipher words",
                 words_sent, letters_checked);
        $display("checked, including empty and full key stores, non-letters and a long hold-off");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
